// ===== rtl/acm_pkg.sv =====
`default_nettype none
package acm_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned HalfWidth  = 64;
  localparam int unsigned CountWidth = 5;
  localparam logic [7:0]  DblPoly    = 8'h87;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
    return w[127 - 8*i -: 8];
  endfunction

  // One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[j + 4*c] = SBOX[get_byte(s, j + 4*((c + j) % 4))];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = t[i];
    end
    return r ^ rk;
  endfunction

  // Next round key from the previous one
  function automatic logic [127:0] next_rkey(input logic [127:0] k, input int rnd);
    logic [31:0]  w0, w1, w2, w3, g;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    g  = {SBOX[w3[23:16]] ^ RCON[rnd], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ g;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // Full AES-128 encryption, ten unrolled rounds
  function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] pt);
    logic [127:0] rk, s;
    rk = key;
    s  = pt ^ key;
    for (int r = 1; r <= 10; r++) begin
      rk = next_rkey(rk, r);
      s  = aes_round(s, rk, r != 10);
    end
    return s;
  endfunction

  // Doubling in GF(2^128)
  function automatic logic [127:0] gf_dbl(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? DblPoly : 8'h00)};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/acm_in_if.sv =====
`default_nettype none
interface acm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic [4:0]  byte_count;
  logic        last_block;

  modport source (output valid, block_high, block_low, byte_count, last_block, input ready);
  modport sink (input valid, block_high, block_low, byte_count, last_block, output ready);
endinterface
`default_nettype wire

// ===== rtl/acm_out_if.sv =====
`default_nettype none
interface acm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] mac_high;
  logic [63:0] mac_low;
  logic        bad_length;

  modport source (output valid, mac_high, mac_low, bad_length, input ready);
  modport sink (input valid, mac_high, mac_low, bad_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/aes_cmac_engine_unit.sv =====
// An accepted block is in the input register at the accepting edge, and its
// result, if any, moves from there into the output register once it is free.
// Throughput: one block per cycle; the whole AES-128 runs unrolled between the
// input register and the chain/result registers. Input stalls only while a result
// waits in the output register and the input register is full.
// Reset (rst_ni low, asynchronous): key, chain and all valid flags clear.
`default_nettype none
module aes_cmac_engine_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire acm_pkg::cfg_reg_e            cfg_idx_i,
  input  wire logic [acm_pkg::HalfWidth-1:0] cfg_data_i,
  acm_in_if.sink                            blk_i,
  acm_out_if.source                         mac_o
);
  import acm_pkg::*;

  logic [127:0] key_q;
  logic [127:0] l_q;
  logic [127:0] chain_q, chain_d;

  logic                  s_valid_q;
  logic [127:0]          s_block_q;
  logic [CountWidth-1:0] s_count_q;
  logic                  s_last_q;

  logic         o_valid_q;
  logic [127:0] o_mac_q;
  logic         o_bad_q;

  logic         out_free, s_fire, s_full, has_result;
  logic [127:0] padded, subkey, aes_in, aes_out, res_mac;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_HIGH: key_q[127:64] <= cfg_data_i;
        REG_KEY_LOW:  key_q[63:0]   <= cfg_data_i;
        default:      key_q         <= key_q;
      endcase
    end
  end

  // Track L = AES(key, 0); registered from the key register
  always_ff @(posedge clk_i) begin
    l_q <= aes_encrypt(key_q, '0);
  end

  assign out_free = !o_valid_q || mac_o.ready;
  assign s_fire   = s_valid_q && out_free;
  assign blk_i.ready = !s_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (blk_i.ready) begin
      s_valid_q <= blk_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_i.ready && blk_i.valid) begin
      s_block_q <= {blk_i.block_high, blk_i.block_low};
      s_count_q <= blk_i.byte_count;
      s_last_q  <= blk_i.last_block;
    end
  end

  // Pad a short block: keep leading bytes, 0x80 marker, zeros after
  assign s_full = s_count_q >= 5'(BlockBytes);
  always_comb begin
    padded = '0;
    for (int i = 0; i < BlockBytes; i++) begin
      if (5'(i) < s_count_q) begin
        padded[127 - 8*i -: 8] = s_block_q[127 - 8*i -: 8];
      end else if (5'(i) == s_count_q) begin
        padded[127 - 8*i -: 8] = PadByte;
      end
    end
  end

  // Select K1 or K2 (none for a non-last block) and run the chain cipher
  always_comb begin
    subkey = '0;
    if (s_last_q) begin
      subkey = s_full ? gf_dbl(l_q) : gf_dbl(gf_dbl(l_q));
    end
    aes_in  = chain_q ^ (s_full ? s_block_q : padded) ^ subkey;
    aes_out = aes_encrypt(key_q, aes_in);
  end

  assign has_result = s_last_q || !s_full;
  assign res_mac    = s_last_q ? aes_out : '0;
  assign chain_d    = has_result ? '0 : aes_out;

  // Chain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else if (s_fire) begin
      chain_q <= chain_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (out_free) begin
      o_valid_q <= s_fire && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && has_result) begin
      o_mac_q <= res_mac;
      o_bad_q <= !s_last_q;
    end
  end

  assign mac_o.valid      = o_valid_q;
  assign mac_o.mac_high   = o_mac_q[127:64];
  assign mac_o.mac_low    = o_mac_q[63:0];
  assign mac_o.bad_length = o_bad_q;

endmodule
`default_nettype wire

// ===== rtl/acm_checker.sv =====
`default_nettype none
module acm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] mac_high,
  input wire logic [63:0] mac_low,
  input wire logic        bad_length
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(mac_high) && $stable(mac_low))
    else $error("stalled result changed");

  // Drop the MAC on a length error
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && bad_length |-> mac_high == 64'd0 && mac_low == 64'd0)
    else $error("length error carries a MAC");

  // Accept input whenever the result side is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // No result without a prior transfer in
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 2))
    else $error("result without input");

endmodule

bind aes_cmac_engine_unit acm_checker u_acm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (blk_i.valid),
  .in_ready   (blk_i.ready),
  .out_valid  (mac_o.valid),
  .out_ready  (mac_o.ready),
  .mac_high   (mac_o.mac_high),
  .mac_low    (mac_o.mac_low),
  .bad_length (mac_o.bad_length)
);
`default_nettype wire

// ===== verif/aes_cmac_engine_unit_tb.sv =====
`default_nettype none
module aes_cmac_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acm_pkg::*;

  typedef struct packed {
    logic [63:0] mac_high;
    logic [63:0] mac_low;
    logic        bad_length;
  } mac_t;

  localparam int unsigned IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  cfg_reg_e    cfg_idx_i = REG_KEY_HIGH;
  logic [63:0] cfg_data_i = '0;

  acm_in_if  blk_if ();
  acm_out_if mac_if ();

  aes_cmac_engine_unit u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .blk_i     (blk_if.sink),
    .mac_o     (mac_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  logic [127:0] key_q;
  logic [127:0] chain_q;
  logic [127:0] lkey_q;
  logic         lkey_ok_q;
  mac_t         mac_exp_q[$];
  int unsigned  mismatches;
  int unsigned  idle_cycles;
  int unsigned  burst_left;
  int unsigned  stall_mode;

  // AES-128 written out byte-wise from the spec
  function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] w[176];
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] k[4];
    logic [7:0] f, a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) w[i] = key[127-8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) k[j] = w[i-4+j];
      if ((i % 16) == 0) begin
        f = k[0];
        k[0] = SBOX[k[1]] ^ RCON[i/16];
        k[1] = SBOX[k[2]];
        k[2] = SBOX[k[3]];
        k[3] = SBOX[f];
      end
      for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ k[j];
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ w[i];
    for (int rd = 1; rd <= 10; rd++) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[j+4*c] = SBOX[s[j+4*((c+j)%4)]];
      if (rd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ {a0[6:0] ^ a1[6:0], 1'b0} ^ ((a0[7] ^ a1[7]) ? 8'h1b : 8'h00);
          t[4*c+1] = a1 ^ al ^ {a1[6:0] ^ a2[6:0], 1'b0} ^ ((a1[7] ^ a2[7]) ? 8'h1b : 8'h00);
          t[4*c+2] = a2 ^ al ^ {a2[6:0] ^ a3[6:0], 1'b0} ^ ((a2[7] ^ a3[7]) ? 8'h1b : 8'h00);
          t[4*c+3] = a3 ^ al ^ {a3[6:0] ^ a0[6:0], 1'b0} ^ ((a3[7] ^ a0[7]) ? 8'h1b : 8'h00);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[16*rd+i];
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  function automatic logic [127:0] times_two(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

  // Advance the CMAC chain by one block, queue the MAC or error if one comes
  task automatic predict_mac(input logic [127:0] blk, input logic [4:0] cnt, input logic lst);
    int unsigned  n;
    logic [127:0] sk;
    logic [127:0] m;
    mac_t         e;
    n = (cnt > 16) ? 16 : cnt;
    if (!lkey_ok_q) begin
      lkey_q = aes128(key_q, '0);
      lkey_ok_q = 1'b1;
    end
    if (!lst) begin
      if (n != 16) begin
        chain_q = '0;
        e = '{mac_high: '0, mac_low: '0, bad_length: 1'b1};
        mac_exp_q.push_back(e);
      end else begin
        chain_q = aes128(key_q, chain_q ^ blk);
      end
      return;
    end
    sk = times_two(lkey_q);
    m  = blk;
    if (n != 16) begin
      sk = times_two(sk);
      for (int i = 0; i < 16; i++)
        if (i >= n) m[127-8*i -: 8] = (i == n) ? PadByte : 8'h00;
    end
    m = aes128(key_q, chain_q ^ m ^ sk);
    chain_q = '0;
    e = '{mac_high: m[127:64], mac_low: m[63:0], bad_length: 1'b0};
    mac_exp_q.push_back(e);
  endtask

  // Send one block in burst/gap style and predict at its transfer
  task automatic send_block(input logic [127:0] blk, input logic [4:0] cnt, input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        blk_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    blk_if.valid      <= 1'b1;
    blk_if.block_high <= blk[127:64];
    blk_if.block_low  <= blk[63:0];
    blk_if.byte_count <= cnt;
    blk_if.last_block <= lst;
    do @(posedge clk_i); while (!blk_if.ready);
    predict_mac(blk, cnt, lst);
    @(negedge clk_i);
  endtask

  // Drop the input, wait for drain, hold past the pipeline, then write a key register
  task automatic write_key(input cfg_reg_e idx, input logic [63:0] val);
    blk_if.valid <= 1'b0;
    burst_left = 0;
    while (mac_exp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_KEY_HIGH) key_q[127:64] = val;
    else key_q[63:0] = val;
    lkey_ok_q = 1'b0;
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Compare each MAC transfer with the oldest expectation
  always @(posedge clk_i) begin
    mac_t got;
    mac_t want;
    if (rst_ni && mac_if.valid && mac_if.ready) begin
      got = '{mac_high: mac_if.mac_high, mac_low: mac_if.mac_low,
              bad_length: mac_if.bad_length};
      if (mac_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = mac_exp_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h_%h bad=%b got %h_%h bad=%b", want.mac_high,
                     want.mac_low, want.bad_length, got.mac_high, got.mac_low,
                     got.bad_length);
        end
      end
    end
  end

  // Stall the receiver on its own pattern
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: mac_if.ready <= 1'b1;
      1: mac_if.ready <= ($urandom_range(0, 3) != 0);
      default: mac_if.ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  // Count cycles without any transfer
  always @(posedge clk_i) begin
    if ((blk_if.valid && blk_if.ready) || (mac_if.valid && mac_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("aes_cmac_engine_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic test_known_vectors();
    write_key(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
    write_key(REG_KEY_LOW, 64'habf7158809cf4f3c);
    send_block('0, 5'd0, 1'b1);
    send_block(128'h6bc1bee22e409f96e93d7e117393172a, 5'd16, 1'b1);
    send_block(128'h6bc1bee22e409f96e93d7e117393172a, 5'd16, 1'b0);
    send_block(128'hae2d8a571e03ac9c9eb76fac45af8e51, 5'd16, 1'b0);
    send_block(128'h30c81c46a35ce411ffffffffffffffff, 5'd8, 1'b1);
  endtask

  task automatic test_edge_cases();
    write_key(REG_KEY_HIGH, '1);
    write_key(REG_KEY_LOW, '1);
    send_block('1, 5'd31, 1'b1);
    send_block('1, 5'd17, 1'b0);
    send_block('1, 5'd15, 1'b1);
    send_block('1, 5'd16, 1'b0);
    send_block('1, 5'd0, 1'b1);
    send_block(rand128(), 5'd16, 1'b0);
    send_block(rand128(), 5'd7, 1'b0);
    send_block(rand128(), 5'd1, 1'b1);
    send_block('0, 5'd0, 1'b0);
    send_block('0, 5'd16, 1'b1);
    write_key(REG_KEY_LOW, '0);
    write_key(REG_KEY_HIGH, '0);
    send_block('1, 5'd16, 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned  sent;
    int unsigned  len;
    logic [4:0]   cnt;
    sent = 0;
    while (sent < 630) begin
      if ($urandom_range(0, 15) == 0) begin
        write_key(REG_KEY_HIGH, {$urandom(), $urandom()});
        if ($urandom_range(0, 1)) write_key(REG_KEY_LOW, {$urandom(), $urandom()});
      end
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
        cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
        send_block(rand128(), cnt, 1'b0);
        sent++;
      end
      cnt = ($urandom_range(0, 2) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
      send_block(rand128(), cnt, 1'b1);
      sent++;
    end
  endtask

  initial begin
    blk_if.valid      = 1'b0;
    blk_if.block_high = '0;
    blk_if.block_low  = '0;
    blk_if.byte_count = '0;
    blk_if.last_block = 1'b0;
    mac_if.ready      = 1'b1;
    key_q = '0; chain_q = '0; lkey_q = '0; lkey_ok_q = 1'b0;
    mismatches = 0; idle_cycles = 0; burst_left = 0; stall_mode = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_known_vectors();
    test_edge_cases();
    test_random_messages();
    blk_if.valid <= 1'b0;
    while (mac_exp_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("aes_cmac_engine_unit_tb OK");
    end else begin
      $display("aes_cmac_engine_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/acm_pkg.sv
rtl/acm_in_if.sv
rtl/acm_out_if.sv
rtl/aes_cmac_engine_unit.sv
rtl/acm_checker.sv
verif/aes_cmac_engine_unit_tb.sv
